// File: rtl/gamepad_poll_responder_with_remap_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gamepad poll responder
// Concurrent checks sampled on the rising clock edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_POLL_RESPONDER_WITH_REMAP_MACROS_SVH
`define GAMEPAD_POLL_RESPONDER_WITH_REMAP_MACROS_SVH

// consequent checked in the same cycle
`define GPRR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gprr assertion failed");

// consequent checked in the next cycle
`define GPRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gprr assertion failed");

`endif

// File: rtl/gprr_pkg.sv
// ----------------------------------------------------------------------------
// gprr_pkg
// Codes, reply constants and button mapping tables of the poll responder.
// ----------------------------------------------------------------------------
package gprr_pkg;

  // request opcodes
  localparam logic [1:0] OP_CMD         = 2'd0;
  localparam logic [1:0] OP_PAD         = 2'd1;
  localparam logic [1:0] OP_SEL_RELEASE = 2'd2;

  // configuration register indexes
  localparam logic [7:0] REG_MAPPING_MODE = 8'd0;
  localparam logic [7:0] REG_DUAL_ANALOG  = 8'd1;

  // poll phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_READY  = 3'd1;
  localparam logic [2:0] PH_BUF0   = 3'd2;
  localparam logic [2:0] PH_BUF1   = 3'd3;
  localparam logic [2:0] PH_STICK  = 3'd4;
  localparam logic [2:0] PH_PRESS  = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;
  localparam logic [2:0] PH_IGNORE = 3'd7;

  // console bytes and replies
  localparam logic [7:0] CMD_POLL_START = 8'h01;
  localparam logic [7:0] CMD_READ       = 8'h42;
  localparam logic [7:0] RPL_ID_DIGITAL = 8'h41;
  localparam logic [7:0] RPL_ID_DUAL    = 8'h79;
  localparam logic [7:0] RPL_READY      = 8'h5A;
  localparam logic [7:0] RPL_STICK      = 8'h7F;
  localparam logic [7:0] RPL_FILL       = 8'hFF;
  localparam logic [7:0] RPL_PRESSED    = 8'hFF;
  localparam logic [7:0] RPL_RELEASED   = 8'h00;

  localparam logic [15:0] BUTTONS_RELEASED = 16'hFFFF;

  localparam int PAD_KEYS     = 12;
  localparam int MAP_TABLES   = 7;
  localparam int NUM_PRESS    = 12;
  localparam int PRESS_IDX_W  = 4;
  localparam logic [2:0] MAP_LIMIT = 3'(MAP_TABLES);

  // console button bit positions in the active-low word
  localparam logic [3:0] CB_LEFT  = 4'd15;
  localparam logic [3:0] CB_DOWN  = 4'd14;
  localparam logic [3:0] CB_RIGHT = 4'd13;
  localparam logic [3:0] CB_UP    = 4'd12;
  localparam logic [3:0] CB_START = 4'd11;
  localparam logic [3:0] CB_SEL   = 4'd8;
  localparam logic [3:0] CB_SQ    = 4'd7;
  localparam logic [3:0] CB_X     = 4'd6;
  localparam logic [3:0] CB_O     = 4'd5;
  localparam logic [3:0] CB_TRI   = 4'd4;
  localparam logic [3:0] CB_R1    = 4'd3;
  localparam logic [3:0] CB_L1    = 4'd2;
  localparam logic [3:0] CB_R2    = 4'd1;
  localparam logic [3:0] CB_L2    = 4'd0;

  // pressure slots
  localparam logic [3:0] PS_R    = 4'd0;
  localparam logic [3:0] PS_L    = 4'd1;
  localparam logic [3:0] PS_U    = 4'd2;
  localparam logic [3:0] PS_D    = 4'd3;
  localparam logic [3:0] PS_TRI  = 4'd4;
  localparam logic [3:0] PS_O    = 4'd5;
  localparam logic [3:0] PS_X    = 4'd6;
  localparam logic [3:0] PS_SQ   = 4'd7;
  localparam logic [3:0] PS_L1   = 4'd8;
  localparam logic [3:0] PS_R1   = 4'd9;
  localparam logic [3:0] PS_L2   = 4'd10;
  localparam logic [3:0] PS_R2   = 4'd11;
  localparam logic [3:0] PS_NONE = 4'd12;

  // columns: pad B, Y, Sel, Start, Up, Down, Left, Right, A, X, L, R
  localparam logic [3:0] ROUTE_BIT [MAP_TABLES][PAD_KEYS] = '{
    '{CB_X,   CB_SQ,  CB_SEL, CB_START, CB_UP,   CB_DOWN, CB_LEFT,  CB_RIGHT,
      CB_O,   CB_TRI, CB_L1,  CB_R1},
    '{CB_O,   CB_X,   CB_SEL, CB_START, CB_UP,   CB_DOWN, CB_LEFT,  CB_RIGHT,
      CB_R2,  CB_TRI, CB_SQ,  CB_R1},
    '{CB_TRI, CB_O,   CB_SEL, CB_START, CB_UP,   CB_DOWN, CB_LEFT,  CB_RIGHT,
      CB_X,   CB_SQ,  CB_L1,  CB_R1},
    '{CB_SQ,  CB_X,   CB_SEL, CB_START, CB_UP,   CB_DOWN, CB_LEFT,  CB_RIGHT,
      CB_TRI, CB_O,   CB_L1,  CB_R1},
    '{CB_O,   CB_TRI, CB_SEL, CB_START, CB_UP,   CB_DOWN, CB_LEFT,  CB_RIGHT,
      CB_SQ,  CB_X,   CB_R1,  CB_L1},
    '{CB_X,   CB_SQ,  CB_SEL, CB_START, CB_UP,   CB_DOWN, CB_LEFT,  CB_RIGHT,
      CB_O,   CB_TRI, CB_L2,  CB_R2},
    '{CB_X,   CB_SQ,  CB_SEL, CB_START, CB_DOWN, CB_UP,   CB_RIGHT, CB_LEFT,
      CB_O,   CB_TRI, CB_R1,  CB_L1}
  };

  localparam logic [3:0] ROUTE_SLOT [MAP_TABLES][PAD_KEYS] = '{
    '{PS_X,   PS_SQ,  PS_NONE, PS_NONE, PS_U, PS_D, PS_L, PS_R,
      PS_O,   PS_TRI, PS_L1,   PS_R1},
    '{PS_O,   PS_X,   PS_NONE, PS_NONE, PS_U, PS_D, PS_L, PS_R,
      PS_R2,  PS_TRI, PS_SQ,   PS_R1},
    '{PS_TRI, PS_O,   PS_NONE, PS_NONE, PS_U, PS_D, PS_L, PS_R,
      PS_X,   PS_SQ,  PS_L1,   PS_R1},
    '{PS_SQ,  PS_X,   PS_NONE, PS_NONE, PS_U, PS_D, PS_L, PS_R,
      PS_TRI, PS_O,   PS_L1,   PS_R1},
    '{PS_O,   PS_TRI, PS_NONE, PS_NONE, PS_U, PS_D, PS_L, PS_R,
      PS_SQ,  PS_X,   PS_R1,   PS_L1},
    '{PS_X,   PS_SQ,  PS_NONE, PS_NONE, PS_U, PS_D, PS_L, PS_R,
      PS_O,   PS_TRI, PS_L2,   PS_R2},
    '{PS_X,   PS_SQ,  PS_NONE, PS_NONE, PS_D, PS_U, PS_R, PS_L,
      PS_O,   PS_TRI, PS_R1,   PS_L1}
  };

  // remapped pad state handed to the poll sequencer
  typedef struct packed {
    logic [15:0]          buttons;
    logic [NUM_PRESS-1:0] pressed;
  } pad_state_t;

endpackage

// File: rtl/gprr_if.sv
// ----------------------------------------------------------------------------
// gprr channel interfaces
// Request, reply and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface gprr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  cmd_byte;
  logic [15:0] pad_buttons;

  modport source(output valid, op, cmd_byte, pad_buttons, input ready);
  modport sink(input valid, op, cmd_byte, pad_buttons, output ready);
endinterface

interface gprr_reply_if;
  logic       valid;
  logic       ready;
  logic       reply_valid;
  logic [7:0] reply_byte;
  logic       ack_pulse;

  modport source(output valid, reply_valid, reply_byte, ack_pulse, input ready);
  modport sink(input valid, reply_valid, reply_byte, ack_pulse, output ready);
endinterface

interface gprr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/gprr_remap.sv
// ----------------------------------------------------------------------------
// gprr_remap
// Maps raw pad bits through the selected table into the console button word
// and the pressure flags, and holds both.
// ----------------------------------------------------------------------------
module gprr_remap (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          mapping_mode,
  input  logic                pad_upd,
  input  logic [15:0]         pad_buttons,
  output gprr_pkg::pad_state_t pad_state
);
  import gprr_pkg::*;

  logic [15:0]          buttons;
  logic [15:0]          buttons_next;
  logic [NUM_PRESS-1:0] pressed;
  logic [NUM_PRESS-1:0] pressed_next;
  logic [2:0]           table_sel;

  // mode 7 falls back to table 0
  assign table_sel = (mapping_mode < MAP_LIMIT) ? mapping_mode : 3'd0;

  always_comb begin
    buttons_next = BUTTONS_RELEASED;
    pressed_next = pressed;
    for (int i = 0; i < PAD_KEYS; i++) begin
      if (!pad_buttons[15 - i]) begin
        buttons_next[ROUTE_BIT[table_sel][i]] = 1'b0;
      end
      // unmapped slots keep their last value
      if (ROUTE_SLOT[table_sel][i] != PS_NONE) begin
        pressed_next[ROUTE_SLOT[table_sel][i]] = !pad_buttons[15 - i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buttons <= BUTTONS_RELEASED;
      pressed <= '0;
    end else if (pad_upd) begin
      buttons <= buttons_next;
      pressed <= pressed_next;
    end
  end

  assign pad_state.buttons = buttons;
  assign pad_state.pressed = pressed;

endmodule

// File: rtl/gprr_poll.sv
// ----------------------------------------------------------------------------
// gprr_poll
// Poll sequencer: walks the reply phases per command byte and registers the
// reply for the output channel.
// ----------------------------------------------------------------------------
`include "gamepad_poll_responder_with_remap_macros.svh"

module gprr_poll #(
  parameter int STICK_BYTES    = 4,
  parameter int PRESSURE_BYTES = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 dual_analog_enable,
  input  gprr_pkg::pad_state_t pad_state,
  gprr_req_if.sink             req,
  gprr_reply_if.source         reply,
  output logic                 pad_upd
);
  import gprr_pkg::*;

  localparam int SW = $clog2(STICK_BYTES + 1);
  localparam int PW = $clog2(PRESSURE_BYTES + 1);
  localparam logic [SW-1:0] STICK_LOAD = SW'(STICK_BYTES);
  localparam logic [PW-1:0] PRESS_LAST = PW'(PRESSURE_BYTES - 1);
  localparam logic [PW-1:0] PRESS_END  = PW'(PRESSURE_BYTES);

  logic [2:0]             phase;
  logic [2:0]             phase_next;
  logic [SW-1:0]          stick_left;
  logic [SW-1:0]          stick_left_next;
  logic [PW-1:0]          press_idx;
  logic [PW-1:0]          press_idx_next;
  logic [PRESS_IDX_W-1:0] press_slot;
  logic                   slot_pressed;
  logic                   full;
  logic                   accept;
  logic                   out_rv;
  logic                   out_rv_next;
  logic [7:0]             out_byte;
  logic [7:0]             out_byte_next;
  logic                   out_ack;
  logic                   out_ack_next;

  // output register frees up in the same cycle it is taken
  assign req.ready = !full || reply.ready;
  assign accept    = req.valid && req.ready;
  assign pad_upd   = accept && (req.op == OP_PAD);

  assign press_slot   = PRESS_IDX_W'(press_idx);
  assign slot_pressed = (press_slot < PRESS_IDX_W'(NUM_PRESS)) && pad_state.pressed[press_slot];

  always_comb begin
    phase_next      = phase;
    stick_left_next = stick_left;
    press_idx_next  = press_idx;
    out_rv_next     = 1'b0;
    out_byte_next   = 8'h00;
    out_ack_next    = 1'b0;
    case (req.op)
      OP_SEL_RELEASE: begin
        phase_next      = PH_IDLE;
        stick_left_next = STICK_LOAD;
        press_idx_next  = '0;
      end
      OP_CMD: begin
        unique case (phase)
          PH_IDLE: begin
            out_rv_next = 1'b1;
            if (req.cmd_byte == CMD_POLL_START) begin
              out_ack_next    = 1'b1;
              out_byte_next   = dual_analog_enable ? RPL_ID_DUAL : RPL_ID_DIGITAL;
              stick_left_next = STICK_LOAD;
              press_idx_next  = '0;
              phase_next      = PH_READY;
            end else begin
              out_byte_next = RPL_FILL;
              phase_next    = PH_IGNORE;
            end
          end
          PH_READY: begin
            // a wrong second byte gets no valid reply byte, only a quiet beat
            if (req.cmd_byte == CMD_READ) begin
              out_rv_next   = 1'b1;
              out_ack_next  = 1'b1;
              out_byte_next = RPL_READY;
              phase_next    = PH_BUF0;
            end
          end
          PH_BUF0: begin
            out_rv_next   = 1'b1;
            out_ack_next  = 1'b1;
            out_byte_next = pad_state.buttons[15:8];
            phase_next    = PH_BUF1;
          end
          PH_BUF1: begin
            out_rv_next   = 1'b1;
            out_ack_next  = 1'b1;
            out_byte_next = pad_state.buttons[7:0];
            phase_next    = dual_analog_enable ? PH_STICK : PH_DONE;
          end
          PH_STICK: begin
            out_rv_next   = 1'b1;
            out_ack_next  = 1'b1;
            out_byte_next = RPL_STICK;
            if (stick_left <= SW'(1)) begin
              stick_left_next = '0;
              phase_next      = PH_PRESS;
            end else begin
              stick_left_next = stick_left - SW'(1);
            end
          end
          PH_PRESS: begin
            out_rv_next   = 1'b1;
            out_ack_next  = 1'b1;
            out_byte_next = slot_pressed ? RPL_PRESSED : RPL_RELEASED;
            if (press_idx >= PRESS_LAST) begin
              press_idx_next = PRESS_END;
              phase_next     = PH_DONE;
            end else begin
              press_idx_next = press_idx + PW'(1);
            end
          end
          PH_DONE: begin
            out_rv_next   = 1'b1;
            out_byte_next = RPL_FILL;
            phase_next    = PH_IDLE;
          end
          default: begin
            // ignoring until select is released
            out_rv_next   = 1'b1;
            out_byte_next = RPL_FILL;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      stick_left <= STICK_LOAD;
      press_idx  <= '0;
      full       <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        stick_left <= stick_left_next;
        press_idx  <= press_idx_next;
        full       <= 1'b1;
      end else if (reply.ready) begin
        full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rv   <= out_rv_next;
      out_byte <= out_byte_next;
      out_ack  <= out_ack_next;
    end
  end

  assign reply.valid       = full;
  assign reply.reply_valid = out_rv;
  assign reply.reply_byte  = out_byte;
  assign reply.ack_pulse   = out_ack;

  `GPRR_ASSERT_NEXT(a_done_to_idle, clk, rst, accept && req.op == OP_CMD && phase == PH_DONE, phase == PH_IDLE)
  `GPRR_ASSERT_NEXT(a_release_reload, clk, rst, accept && req.op == OP_SEL_RELEASE, phase == PH_IDLE && stick_left == STICK_LOAD && press_idx == '0)
  `GPRR_ASSERT_SAME(a_stick_nonzero, clk, rst, phase == PH_STICK, stick_left != '0)
  `GPRR_ASSERT_SAME(a_quiet_no_reply, clk, rst, full && !out_rv, out_byte == 8'h00 && !out_ack)

endmodule

// File: rtl/gamepad_poll_responder_with_remap.sv
// ----------------------------------------------------------------------------
// gamepad_poll_responder_with_remap
// Replies are registered and appear in the cycle after the request is taken.
// Throughput: one request per cycle; the reply register is reloaded while
// its contents are taken, so only a stalled reply channel holds off requests.
// Reset: synchronous; idle phase, counters reloaded, buttons released,
// mapping table 0, digital mode.
// ----------------------------------------------------------------------------
module gamepad_poll_responder_with_remap #(
  parameter int STICK_BYTES    = 4,
  parameter int PRESSURE_BYTES = 12
) (
  input logic          clk,
  input logic          rst,
  gprr_req_if.sink     req,
  gprr_reply_if.source reply,
  gprr_cfg_if.sink     cfg
);
  import gprr_pkg::*;

  logic [2:0] mapping_mode;
  logic       dual_analog_enable;
  logic       pad_upd;
  pad_state_t pad_state;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapping_mode       <= 3'd0;
      dual_analog_enable <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MAPPING_MODE: mapping_mode       <= cfg.data[2:0];
        REG_DUAL_ANALOG:  dual_analog_enable <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  gprr_remap u_remap (
    .clk          (clk),
    .rst          (rst),
    .mapping_mode (mapping_mode),
    .pad_upd      (pad_upd),
    .pad_buttons  (req.pad_buttons),
    .pad_state    (pad_state)
  );

  gprr_poll #(
    .STICK_BYTES    (STICK_BYTES),
    .PRESSURE_BYTES (PRESSURE_BYTES)
  ) u_poll (
    .clk                (clk),
    .rst                (rst),
    .dual_analog_enable (dual_analog_enable),
    .pad_state          (pad_state),
    .req                (req),
    .reply              (reply),
    .pad_upd            (pad_upd)
  );

endmodule
